// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define SGMT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgmt check failed");

// Next-cycle implication.
`define SGMT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgmt check failed");

`endif

// ----- sv/sgmt_pkg.sv -----
`default_nettype none

package sgmt_pkg;

  localparam int unsigned NODES    = 1024;
  localparam int unsigned BRANCHES = 8;
  localparam int unsigned NODE_W   = $clog2(NODES);
  localparam int unsigned ID_W     = 16;
  localparam int unsigned CNT_W    = $clog2(BRANCHES + 1);

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_CONTAINS = 2'd2,
    REQ_SHARES   = 2'd3
  } req_e;

  typedef logic [BRANCHES-1:0][ID_W-1:0] row_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    row_t             row;
  } word_t;

  localparam int unsigned WORD_W = $bits(word_t);

  typedef struct packed {
    logic  we;
    logic  flag;
    logic  err;
    word_t word;
  } upd_t;

endpackage

`default_nettype wire

// ----- sv/sgmt_mem.sv -----
`default_nettype none

// One wide word per node: count and sorted id list. One write, two reads.
module sgmt_mem (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [sgmt_pkg::NODE_W-1:0]  waddr_i,
  input  wire sgmt_pkg::word_t              wdata_i,
  input  wire logic                         re_i,
  input  wire logic [sgmt_pkg::NODE_W-1:0]  raddr_a_i,
  input  wire logic [sgmt_pkg::NODE_W-1:0]  raddr_b_i,
  output sgmt_pkg::word_t                   rdata_a_o,
  output sgmt_pkg::word_t                   rdata_b_o
);

  logic [sgmt_pkg::WORD_W-1:0] mem_q [sgmt_pkg::NODES];
  logic [sgmt_pkg::WORD_W-1:0] rdata_a_q;
  logic [sgmt_pkg::WORD_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = sgmt_pkg::word_t'(rdata_a_q);
  assign rdata_b_o = sgmt_pkg::word_t'(rdata_b_q);

endmodule

`default_nettype wire

// ----- sv/sgmt_upd.sv -----
`default_nettype none

// Parallel compare and insert/remove shift on one node word; shares match across two node words.
module sgmt_upd (
  input  wire sgmt_pkg::req_e                 req_type_i,
  input  wire logic [sgmt_pkg::ID_W-1:0]      group_id_i,
  input  wire sgmt_pkg::word_t                word_a_i,
  input  wire sgmt_pkg::word_t                word_b_i,
  output sgmt_pkg::upd_t                      upd_o
);

  logic [sgmt_pkg::BRANCHES-1:0] lt;
  logic [sgmt_pkg::BRANCHES-1:0] eq;
  logic [sgmt_pkg::CNT_W-1:0]    pos;
  logic                          found;
  logic                          hit;
  logic                          full;
  logic                          gz;
  sgmt_pkg::row_t                ins_row;
  sgmt_pkg::row_t                rem_row;

  always_comb begin
    for (int i = 0; i < sgmt_pkg::BRANCHES; i++) begin
      lt[i] = (sgmt_pkg::CNT_W'(i) < word_a_i.cnt) && (word_a_i.row[i] < group_id_i);
      eq[i] = (sgmt_pkg::CNT_W'(i) < word_a_i.cnt) && (word_a_i.row[i] == group_id_i);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < sgmt_pkg::BRANCHES; i++) begin
      pos = pos + sgmt_pkg::CNT_W'(lt[i]);
    end
  end

  assign found = |eq;
  assign full  = word_a_i.cnt >= sgmt_pkg::CNT_W'(sgmt_pkg::BRANCHES);
  assign gz    = group_id_i != '0;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < sgmt_pkg::BRANCHES; i++) begin
      for (int j = 0; j < sgmt_pkg::BRANCHES; j++) begin
        if ((sgmt_pkg::CNT_W'(i) < word_a_i.cnt) && (sgmt_pkg::CNT_W'(j) < word_b_i.cnt) &&
            (word_a_i.row[i] == word_b_i.row[j])) begin
          hit = 1'b1;
        end
      end
    end
  end

  // insert: open a gap at pos; remove: close the gap at pos
  always_comb begin
    ins_row[0] = (pos == '0) ? group_id_i : word_a_i.row[0];
    for (int k = 1; k < sgmt_pkg::BRANCHES; k++) begin
      if (sgmt_pkg::CNT_W'(k) < pos) begin
        ins_row[k] = word_a_i.row[k];
      end else if (sgmt_pkg::CNT_W'(k) == pos) begin
        ins_row[k] = group_id_i;
      end else begin
        ins_row[k] = word_a_i.row[k-1];
      end
    end
    for (int k = 0; k < sgmt_pkg::BRANCHES - 1; k++) begin
      rem_row[k] = (sgmt_pkg::CNT_W'(k) < pos) ? word_a_i.row[k] : word_a_i.row[k+1];
    end
    rem_row[sgmt_pkg::BRANCHES-1] = word_a_i.row[sgmt_pkg::BRANCHES-1];
  end

  always_comb begin
    upd_o      = '0;
    upd_o.word = word_a_i;
    case (req_type_i)
      sgmt_pkg::REQ_INSERT: begin
        if (gz) begin
          if (full) begin
            upd_o.err = 1'b1;
          end else if (!found) begin
            upd_o.we       = 1'b1;
            upd_o.flag     = 1'b1;
            upd_o.word.row = ins_row;
            upd_o.word.cnt = word_a_i.cnt + sgmt_pkg::CNT_W'(1);
          end
        end
      end
      sgmt_pkg::REQ_REMOVE: begin
        if (gz && found) begin
          upd_o.we       = 1'b1;
          upd_o.flag     = 1'b1;
          upd_o.word.row = rem_row;
          upd_o.word.cnt = word_a_i.cnt - sgmt_pkg::CNT_W'(1);
        end
      end
      sgmt_pkg::REQ_CONTAINS: begin
        upd_o.flag = gz && found;
      end
      sgmt_pkg::REQ_SHARES: begin
        upd_o.flag = hit;
      end
      default: begin
        upd_o.flag = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/sorted_group_membership_table.sv -----
// channel | handshake             | payload
// --------+-----------------------+---------------------------------------------------
// in      | in_valid_i/in_ready_o | req_type_i, node_index_i, other_node_index_i, group_id_i
// out     | out_valid_o/out_ready_i | result_flag_o, full_error_o
//
// Each request is a node word read from the node memory, then compare/shift
// and write-back in the same memory; one request in flight.
// After reset a clearing pass zeroes every node in turn; in_ready_o is low.
// A result waits in the output register; a full output register holds the
// compare/write-back step until taken. No other stalls.
`default_nettype none

module sorted_group_membership_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [sgmt_pkg::NODE_W-1:0]  node_index_i,
  input  wire logic [sgmt_pkg::NODE_W-1:0]  other_node_index_i,
  input  wire logic [sgmt_pkg::ID_W-1:0]    group_id_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              result_flag_o,
  output logic                              full_error_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [sgmt_pkg::NODE_W-1:0]     clr_q, clr_d;
  logic [sgmt_pkg::NODE_W-1:0]     node_q;
  sgmt_pkg::req_e                  req_q;
  logic [sgmt_pkg::ID_W-1:0]       gid_q;
  logic                            out_valid_q, out_valid_d;
  logic                            flag_q;
  logic                            err_q;

  logic                            accept;
  logic                            fire;
  logic                            mem_we;
  logic [sgmt_pkg::NODE_W-1:0]     mem_waddr;
  sgmt_pkg::word_t                 mem_wdata;
  sgmt_pkg::word_t                 rd_a;
  sgmt_pkg::word_t                 rd_b;
  sgmt_pkg::upd_t                  upd;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + sgmt_pkg::NODE_W'(1);
        if (clr_q == sgmt_pkg::NODE_W'(sgmt_pkg::NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = fire && upd.we;
      mem_waddr = node_q;
      mem_wdata = upd.word;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q <= node_index_i;
      req_q  <= sgmt_pkg::req_e'(req_type_i);
      gid_q  <= group_id_i;
    end
    if (fire) begin
      flag_q <= upd.flag;
      err_q  <= upd.err;
    end
  end

  sgmt_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (accept),
    .raddr_a_i (node_index_i),
    .raddr_b_i (other_node_index_i),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  sgmt_upd u_upd (
    .req_type_i (req_q),
    .group_id_i (gid_q),
    .word_a_i   (rd_a),
    .word_b_i   (rd_b),
    .upd_o      (upd)
  );

  assign out_valid_o   = out_valid_q;
  assign result_flag_o = flag_q;
  assign full_error_o  = err_q;

endmodule

`default_nettype wire

// ----- sv/sgmt_chk.sv -----
`default_nettype none

`include "assert_macros.svh"

module sgmt_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic                         result_flag_o,
  input wire logic                         full_error_o
);

  // one request in flight: busy the cycle after a request is taken
  `SGMT_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)

  // a full insert never reports success
  `SGMT_ASSERT_IMP(a_err_excl_flag, out_valid_o && full_error_o, !result_flag_o)

  `SGMT_ASSERT_NXT(a_out_held, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind sorted_group_membership_table sgmt_chk u_sgmt_chk (.*);

`default_nettype wire

// ----- tb/sv/group_table_checker.sv -----
module group_table_checker import sgmt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        req_type_i,
  input  logic [NODE_W-1:0] node_index_i,
  input  logic [NODE_W-1:0] other_node_index_i,
  input  logic [ID_W-1:0]   group_id_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              result_flag_i,
  input  logic              full_error_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic flag;
    logic err;
  } verdict_t;

  logic [ID_W-1:0] slots [NODES][BRANCHES];
  int unsigned     fill [NODES];
  verdict_t        expected_verdicts [$];
  verdict_t        want;
  verdict_t        got;
  int              mismatches;

  function automatic verdict_t apply_request(req_e kind, int unsigned n, int unsigned m,
                                             logic [ID_W-1:0] g);
    verdict_t    v;
    int unsigned cnt, cnt2, p, i, j, k;
    logic        found;
    v    = '0;
    cnt  = (fill[n] > BRANCHES) ? BRANCHES : fill[n];
    cnt2 = (fill[m] > BRANCHES) ? BRANCHES : fill[m];
    if (kind == REQ_SHARES) begin
      i = 0;
      j = 0;
      while (i < cnt && j < cnt2 && !v.flag) begin
        if (slots[n][i] < slots[m][j]) begin
          i++;
        end else if (slots[n][i] > slots[m][j]) begin
          j++;
        end else begin
          v.flag = 1'b1;
        end
      end
    end else if (g != '0) begin
      p = 0;
      while (p < cnt && slots[n][p] < g) p++;
      found = (p < cnt) && (slots[n][p] == g);
      case (kind)
        REQ_INSERT: begin
          if (cnt >= BRANCHES) begin
            v.err = 1'b1;
          end else if (!found) begin
            for (k = cnt; k > p; k--) slots[n][k] = slots[n][k-1];
            slots[n][p] = g;
            fill[n]     = cnt + 1;
            v.flag      = 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (found) begin
            for (k = p; k + 1 < cnt; k++) slots[n][k] = slots[n][k+1];
            slots[n][cnt-1] = '0;
            fill[n]         = cnt - 1;
            v.flag          = 1'b1;
          end
        end
        default: v.flag = found;
      endcase
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slots[n, b]) slots[n][b] = '0;
      foreach (fill[n]) fill[n] = 0;
      expected_verdicts.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.flag = result_flag_i;
        got.err  = full_error_i;
        if (expected_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no request pending: flag=%0b err=%0b",
                     $time, got.flag, got.err);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: result mismatch: exp flag=%0b err=%0b, got flag=%0b err=%0b",
                       $time, want.flag, want.err, got.flag, got.err);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_verdicts.push_back(apply_request(req_e'(req_type_i), node_index_i % NODES,
                                                  other_node_index_i % NODES, group_id_i));
      fail_count_o <= mismatches;
      pending_o    <= expected_verdicts.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sgmt_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  req_e              req_type = REQ_INSERT;
  logic [NODE_W-1:0] node_index = '0;
  logic [NODE_W-1:0] other_index = '0;
  logic [ID_W-1:0]   group_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              result_flag;
  logic              full_error;
  int                fail_count;
  int                pending;
  bit                calm = 1'b0;

  always #6 clk_i = ~clk_i;

  sorted_group_membership_table u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .req_type_i         (req_type),
    .node_index_i       (node_index),
    .other_node_index_i (other_index),
    .group_id_i         (group_id),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .result_flag_o      (result_flag),
    .full_error_o       (full_error)
  );

  group_table_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .req_type_i         (req_type),
    .node_index_i       (node_index),
    .other_node_index_i (other_index),
    .group_id_i         (group_id),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .result_flag_i      (result_flag),
    .full_error_i       (full_error),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  task automatic send_req(input req_e kind, input logic [NODE_W-1:0] n,
                          input logic [NODE_W-1:0] m, input logic [ID_W-1:0] g);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    node_index  <= n;
    other_index <= m;
    group_id    <= g;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // hold requests back until every result is in
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [ID_W-1:0]   fill_ids [8];
    logic [NODE_W-1:0] node_pool [6];
    logic [ID_W-1:0]   id_pool [24];
    int unsigned       pool_ids, ins_w, r, waited;
    req_e              kind;

    fill_ids = '{16'hFFFF, 16'h9000, 16'h7000, 16'h5000, 16'h3000, 16'h1000, 16'h0002,
                 16'h0001};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero id is a no-op
    send_req(REQ_INSERT,   10'd0,    10'd0,    16'h0000);
    send_req(REQ_CONTAINS, 10'd0,    10'd0,    16'h0000);
    send_req(REQ_REMOVE,   10'd0,    10'd0,    16'h0000);
    send_req(REQ_INSERT,   10'd1023, 10'd0,    16'hFFFF);
    send_req(REQ_INSERT,   10'd1023, 10'd0,    16'hFFFF);
    // fill a node in descending order, then overflow it
    foreach (fill_ids[i]) send_req(REQ_INSERT, 10'd5, 10'd0, fill_ids[i]);
    send_req(REQ_INSERT,   10'd5,    10'd0,    16'h6000);
    send_req(REQ_INSERT,   10'd5,    10'd0,    16'h7000);
    send_req(REQ_CONTAINS, 10'd5,    10'd0,    16'h7000);
    send_req(REQ_REMOVE,   10'd5,    10'd0,    16'h6000);
    send_req(REQ_REMOVE,   10'd5,    10'd0,    16'h7000);
    send_req(REQ_INSERT,   10'd5,    10'd0,    16'h6000);
    send_req(REQ_SHARES,   10'd5,    10'd5,    16'h1234);
    send_req(REQ_SHARES,   10'd2,    10'd2,    16'h0001);
    send_req(REQ_SHARES,   10'd5,    10'd1023, 16'hABCD);
    send_req(REQ_SHARES,   10'd0,    10'd1023, 16'h0000);
    send_req(REQ_CONTAINS, 10'd1023, 10'd0,    16'hFFFE);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      calm     = ($urandom_range(0, 3) == 0);
      ins_w    = $urandom_range(25, 70);
      pool_ids = $urandom_range(4, 24);
      foreach (node_pool[i]) node_pool[i] = NODE_W'($urandom_range(0, NODES - 1));
      foreach (id_pool[i])
        id_pool[i] = $urandom_range(0, 1) ? ID_W'($urandom_range(1, 40)) :
                                            ID_W'($urandom_range(1, 65535));
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(0, 99) < 12) begin
          send_req(req_e'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 1023)),
                   NODE_W'($urandom_range(0, 1023)), ID_W'($urandom_range(0, 65535)));
        end else begin
          r = $urandom_range(0, 99);
          if (r < ins_w) kind = REQ_INSERT;
          else if (r < ins_w + (100 - ins_w) * 2 / 5) kind = REQ_REMOVE;
          else if (r < ins_w + (100 - ins_w) * 7 / 10) kind = REQ_CONTAINS;
          else kind = REQ_SHARES;
          send_req(kind, node_pool[$urandom_range(0, 5)], node_pool[$urandom_range(0, 5)],
                   id_pool[$urandom_range(0, pool_ids - 1)]);
        end
      end
      if ($urandom_range(0, 3) == 0) drain();
    end

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < 4000);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
